/* design/efp_pkg.sv */
package efp_pkg;

    localparam int COORD_BITS = 32;
    localparam int COUNT_BITS = 24;
    localparam int LIMIT_BITS = 24;
    localparam int WIDTH_REG_BITS = 13;
    localparam int QUEUE_DEPTH = 2;

    localparam int DEF_MAX_WIDTH = 4096;
    localparam int DEF_INDEX_BITS = 24;
    localparam int DEF_FRAC_BITS = 28;

    // register indexes on the config port
    localparam logic [2:0] REG_ITER_LIMIT = 3'd0;
    localparam logic [2:0] REG_IMAGE_WIDTH = 3'd1;
    localparam logic [2:0] REG_X_LEFT = 3'd2;
    localparam logic [2:0] REG_X_STEP = 3'd3;
    localparam logic [2:0] REG_Y_BOTTOM = 3'd4;
    localparam logic [2:0] REG_Y_STEP = 3'd5;

    // point c handed from the front part to the iteration engine
    typedef struct packed {
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
    } point_t;

    typedef struct packed {
        logic [LIMIT_BITS-1:0] iter_limit;
        logic [WIDTH_REG_BITS-1:0] image_width;
        logic [COORD_BITS-1:0] x_left;
        logic [COORD_BITS-1:0] x_step;
        logic [COORD_BITS-1:0] y_bottom;
        logic [COORD_BITS-1:0] y_step;
    } cfg_t;

endpackage

/* design/efp_front.sv */
module efp_front #(
    parameter int MAX_WIDTH = efp_pkg::DEF_MAX_WIDTH,
    parameter int INDEX_BITS = efp_pkg::DEF_INDEX_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  efp_pkg::cfg_t         cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [INDEX_BITS-1:0] in_index,
    output logic                  push,
    output efp_pkg::point_t       push_point,
    input  logic                  queue_full
);

    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int CB = $clog2(INDEX_BITS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_PUSH
    } state_t;

    state_t                   state_reg;
    logic [WB-1:0]            w_reg;
    logic [WB-1:0]            rem_reg;
    logic [INDEX_BITS-1:0]    quo_reg;
    logic [CB-1:0]            cnt_reg;
    logic [efp_pkg::COORD_BITS-1:0] px_reg;
    logic [efp_pkg::COORD_BITS-1:0] py_reg;

    logic [31:0]   width32;
    logic [WB-1:0] w_sat;
    logic [WB:0]   rem_sh;
    logic          sub_ok;

    always_comb begin
        width32 = 32'(cfg.image_width);
        if (width32 == 32'd0) begin
            w_sat = WB'(1);
        end else if (width32 > 32'(MAX_WIDTH)) begin
            w_sat = WB'(MAX_WIDTH);
        end else begin
            w_sat = WB'(width32);
        end
    end

    // restoring division, one quotient bit per cycle
    assign rem_sh = {rem_reg, quo_reg[INDEX_BITS-1]};
    assign sub_ok = rem_sh >= {1'b0, w_reg};

    assign in_ready = (state_reg == ST_IDLE);
    assign push = (state_reg == ST_PUSH) && !queue_full;
    assign push_point.cx = cfg.x_left + px_reg;
    assign push_point.cy = cfg.y_bottom + py_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        w_reg <= w_sat;
                        rem_reg <= '0;
                        quo_reg <= in_index;
                        cnt_reg <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg <= sub_ok ? WB'(rem_sh - {1'b0, w_reg}) : WB'(rem_sh);
                    quo_reg <= {quo_reg[INDEX_BITS-2:0], sub_ok};
                    cnt_reg <= cnt_reg + CB'(1);
                    if (cnt_reg == CB'(INDEX_BITS - 1)) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    // col = remainder, row = quotient; only low 32 bits matter
                    px_reg <= efp_pkg::COORD_BITS'(rem_reg * cfg.x_step);
                    py_reg <= efp_pkg::COORD_BITS'(quo_reg * cfg.y_step);
                    state_reg <= ST_PUSH;
                end
                ST_PUSH: begin
                    if (!queue_full) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

/* design/efp_queue.sv */
module efp_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  efp_pkg::point_t push_point,
    output logic            full,
    input  logic            pop,
    output efp_pkg::point_t pop_point,
    output logic            empty
);

    localparam int AB = $clog2(efp_pkg::QUEUE_DEPTH);

    efp_pkg::point_t mem_reg [efp_pkg::QUEUE_DEPTH];
    logic [AB-1:0]   wr_reg;
    logic [AB-1:0]   rd_reg;
    logic [AB:0]     cnt_reg;

    assign full = (cnt_reg == (AB+1)'(efp_pkg::QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign pop_point = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_reg] <= push_point;
        end
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push && !full) begin
                wr_reg <= (wr_reg == AB'(efp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_reg + AB'(1);
            end
            if (pop && !empty) begin
                rd_reg <= (rd_reg == AB'(efp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_reg + AB'(1);
            end
            cnt_reg <= cnt_reg + (AB+1)'(push && !full) - (AB+1)'(pop && !empty);
        end
    end

endmodule

/* design/efp_back.sv */
module efp_back #(
    parameter int FRAC_BITS = efp_pkg::DEF_FRAC_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [efp_pkg::LIMIT_BITS-1:0]    iter_limit,
    input  logic                              q_empty,
    input  efp_pkg::point_t                   q_point,
    output logic                              q_pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [efp_pkg::COUNT_BITS-1:0]    out_count
);

    localparam bit REACH = (2 * FRAC_BITS + 2) < 64;
    localparam logic [63:0] THRESH = REACH ? (64'd1 << (2 * FRAC_BITS + 2)) : 64'd0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_STEP,
        ST_DONE
    } state_t;

    state_t                           state_reg;
    logic [efp_pkg::COORD_BITS-1:0]   cx_reg, cy_reg, x_reg, y_reg;
    logic signed [63:0]               pxx_reg, pyy_reg, pxy_reg;
    logic [efp_pkg::COUNT_BITS-1:0]   n_reg;
    logic                             ov_reg;
    logic [efp_pkg::COUNT_BITS-1:0]   cnt_out_reg;

    logic signed [63:0]             sxx, syy, sxy;
    logic [efp_pkg::COORD_BITS-1:0] nx, ny;
    logic [63:0]                    len2;
    logic                           escaped;

    always_comb begin
        sxx = pxx_reg >>> FRAC_BITS;
        syy = pyy_reg >>> FRAC_BITS;
        sxy = pxy_reg >>> FRAC_BITS;
        nx = sxx[31:0] - syy[31:0] + cx_reg;
        ny = {sxy[30:0], 1'b0} + cy_reg;
        // squares of the current z are |z|^2 of the previous step
        len2 = $unsigned(pxx_reg) + $unsigned(pyy_reg);
        escaped = REACH && (n_reg != '0) && (len2 >= THRESH);
    end

    assign q_pop = (state_reg == ST_IDLE) && !q_empty;
    assign out_valid = ov_reg;
    assign out_count = cnt_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ov_reg <= 1'b0;
        end else begin
            // ST_DONE handles its own output handshake below
            if (ov_reg && out_ready && state_reg != ST_DONE) begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        cx_reg <= q_point.cx;
                        cy_reg <= q_point.cy;
                        x_reg <= '0;
                        y_reg <= '0;
                        n_reg <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    pxx_reg <= $signed(x_reg) * $signed(x_reg);
                    pyy_reg <= $signed(y_reg) * $signed(y_reg);
                    pxy_reg <= $signed(x_reg) * $signed(y_reg);
                    state_reg <= ST_STEP;
                end
                ST_STEP: begin
                    if (escaped || n_reg >= iter_limit) begin
                        state_reg <= ST_DONE;
                    end else begin
                        x_reg <= nx;
                        y_reg <= ny;
                        n_reg <= n_reg + efp_pkg::COUNT_BITS'(1);
                        state_reg <= ST_MUL;
                    end
                end
                ST_DONE: begin
                    if (!ov_reg || out_ready) begin
                        ov_reg <= 1'b1;
                        cnt_out_reg <= n_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

/* design/escape_time_fractal_pixel_core.sv */
// Escape-time fractal pixel core (Mandelbrot iteration, signed fixed point).
//
// Input stream (s_*): one transfer carries one linear pixel index in tdata.
// Output stream (m_*): one transfer per pixel carries the escape count.
// APB port: iteration limit, image width, x left/step, y bottom/step at
// byte addresses 0, 4, 8, 12, 16, 20. Write only while the core is idle.
//
// Flow: the front accepts an index, splits it into column/row with a serial
// divider, forms c with two parallel multiplies and pushes it. The back
// engine pops a point and runs each iteration as a multiply, then an
// update/escape check; after the final check the count goes into the output
// register. The front can take a new index while the engine is still
// iterating on an earlier point.
// The front accepts a new index once its previous point is queued; with the
// two-entry queue full it holds one more, up to three points ahead.
// Reset (aresetn low, synchronous) empties the queue, drops any pending
// result and restores register defaults. When the receiver stalls the
// result holds in the output register; the engine and then the front
// stop once the queue fills.
module escape_time_fractal_pixel_core #(
    parameter int MAX_WIDTH = efp_pkg::DEF_MAX_WIDTH,
    parameter int INDEX_BITS = efp_pkg::DEF_INDEX_BITS,
    parameter int FRAC_BITS = efp_pkg::DEF_FRAC_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [((INDEX_BITS + 7) / 8) * 8 - 1:0] s_tdata, // [INDEX_BITS-1:0] pixel_index
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // [23:0] escape_count
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    efp_pkg::cfg_t   cfg_reg;
    efp_pkg::point_t push_point, pop_point;
    logic            push, pop, q_full, q_empty;
    logic [2:0]      reg_idx;

    assign pready = 1'b1;
    assign reg_idx = paddr[4:2];

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.iter_limit <= 24'd1024;
            cfg_reg.image_width <= 13'd1024;
            cfg_reg.x_left <= 32'hE000_0000;
            cfg_reg.x_step <= 32'd1048576;
            cfg_reg.y_bottom <= 32'hE000_0000;
            cfg_reg.y_step <= 32'd1048576;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                efp_pkg::REG_ITER_LIMIT:  cfg_reg.iter_limit <= pwdata[23:0];
                efp_pkg::REG_IMAGE_WIDTH: cfg_reg.image_width <= pwdata[12:0];
                efp_pkg::REG_X_LEFT:      cfg_reg.x_left <= pwdata;
                efp_pkg::REG_X_STEP:      cfg_reg.x_step <= pwdata;
                efp_pkg::REG_Y_BOTTOM:    cfg_reg.y_bottom <= pwdata;
                efp_pkg::REG_Y_STEP:      cfg_reg.y_step <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            efp_pkg::REG_ITER_LIMIT:  prdata = 32'(cfg_reg.iter_limit);
            efp_pkg::REG_IMAGE_WIDTH: prdata = 32'(cfg_reg.image_width);
            efp_pkg::REG_X_LEFT:      prdata = cfg_reg.x_left;
            efp_pkg::REG_X_STEP:      prdata = cfg_reg.x_step;
            efp_pkg::REG_Y_BOTTOM:    prdata = cfg_reg.y_bottom;
            efp_pkg::REG_Y_STEP:      prdata = cfg_reg.y_step;
            default:                  prdata = 32'd0;
        endcase
    end

    efp_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .INDEX_BITS(INDEX_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_index  (s_tdata[INDEX_BITS-1:0]),
        .push      (push),
        .push_point(push_point),
        .queue_full(q_full)
    );

    efp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_point(push_point),
        .full      (q_full),
        .pop       (pop),
        .pop_point (pop_point),
        .empty     (q_empty)
    );

    efp_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .iter_limit(cfg_reg.iter_limit),
        .q_empty   (q_empty),
        .q_point   (pop_point),
        .q_pop     (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_count (m_tdata)
    );

endmodule

/* design/efp_checker.sv */
module efp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // a stalled result stays put
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed under stall");

    // reset clears any pending result
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // front comes out of reset ready
    assert property (@(posedge aclk) !aresetn |=> s_tready)
        else $error("input not ready after reset");

    // divider is busy right after a transfer in
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("front ready while dividing");

endmodule

bind escape_time_fractal_pixel_core efp_checker u_efp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    // ------------------------------------------------------------------
    // Clock, reset, bus signals
    // ------------------------------------------------------------------
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;     // [23:0] pixel_index
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;          // [23:0] escape_count
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    escape_time_fractal_pixel_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the register file, kept in step with every APB write
    // ------------------------------------------------------------------
    logic [efp_pkg::LIMIT_BITS-1:0]     sh_limit = 24'd1024;
    logic [efp_pkg::WIDTH_REG_BITS-1:0] sh_width = 13'd1024;
    logic [31:0] sh_x_left = 32'hE000_0000;
    logic [31:0] sh_x_step = 32'd1048576;
    logic [31:0] sh_y_bottom = 32'hE000_0000;
    logic [31:0] sh_y_step = 32'd1048576;

    logic [23:0] expected_counts[$];

    int unsigned mismatches = 0;
    int unsigned pixels_sent = 0;
    int unsigned counts_checked = 0;
    int unsigned reg_writes = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    bit          backpressure_req = 1'b0;
    bit          apb_fired = 1'b0;

    // clamp width the way the core does: 0 -> 1, above max -> max
    function automatic int unsigned eff_width();
        int unsigned w;
        w = sh_width;
        if (w == 0) w = 1;
        if (w > efp_pkg::DEF_MAX_WIDTH) w = efp_pkg::DEF_MAX_WIDTH;
        return w;
    endfunction

    // Mandelbrot escape time for one pixel under the shadow registers
    function automatic logic [23:0] escape_count_of(logic [23:0] pix);
        int unsigned w, col, row, n;
        logic [31:0] cx, cy, zx, zy, nx, ny;
        longint sx, sy, xx, yy, xy;
        longint unsigned mag2, thresh;
        w = eff_width();
        col = pix % w;
        row = pix / w;
        cx = sh_x_left + col * sh_x_step;
        cy = sh_y_bottom + row * sh_y_step;
        zx = '0;
        zy = '0;
        mag2 = 0;
        thresh = 64'd1 << (2 * efp_pkg::DEF_FRAC_BITS + 2);
        n = 0;
        while (n < sh_limit && mag2 < thresh) begin
            sx = longint'(signed'(zx));
            sy = longint'(signed'(zy));
            xx = sx * sx;
            yy = sy * sy;
            xy = sx * sy;
            nx = 32'(xx >>> efp_pkg::DEF_FRAC_BITS) - 32'(yy >>> efp_pkg::DEF_FRAC_BITS)
                 + cx;
            ny = 32'(32'(xy >>> efp_pkg::DEF_FRAC_BITS) << 1) + cy;
            zx = nx;
            zy = ny;
            sx = longint'(signed'(zx));
            sy = longint'(signed'(zy));
            mag2 = longint'(sx * sx) + longint'(sy * sy);
            n++;
        end
        return n[23:0];
    endfunction

    // ------------------------------------------------------------------
    // APB write; waits until the core has drained
    // ------------------------------------------------------------------
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        while (expected_counts.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        // register is written at this edge
        apb_fired = 1'b1;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            efp_pkg::REG_ITER_LIMIT:  sh_limit = val[23:0];
            efp_pkg::REG_IMAGE_WIDTH: sh_width = val[12:0];
            efp_pkg::REG_X_LEFT:      sh_x_left = val;
            efp_pkg::REG_X_STEP:      sh_x_step = val;
            efp_pkg::REG_Y_BOTTOM:    sh_y_bottom = val;
            efp_pkg::REG_Y_STEP:      sh_y_step = val;
            default: ;
        endcase
        reg_writes++;
    endtask

    // Offer one pixel; hold tvalid until the transfer. A typed expectation
    // (use_typed) replaces the computed one for the directed rows.
    task automatic send_pixel(logic [23:0] pix, bit use_typed, logic [23:0] typed);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(0, 99) < tx_idle_pct) gap++;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
        expected_counts.push_back(use_typed ? typed : escape_count_of(pix));
        pixels_sent++;
    endtask

    // ------------------------------------------------------------------
    // Result side: check each transfer, drive tready with random stalls
    // and an occasional long hold-off
    // ------------------------------------------------------------------
    int unsigned hold_left = 0;

    always @(posedge aclk) begin
        logic [23:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_counts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: count %0d", m_tdata);
            end else begin
                want = expected_counts.pop_front();
                counts_checked++;
                if (m_tdata !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("escape_count mismatch: expected %0d got %0d",
                                 want, m_tdata);
                end
            end
        end
        if (backpressure_req && hold_left == 0) begin
            hold_left = 3000;
            backpressure_req = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Watchdog: cycles without any transfer or register write
    int unsigned quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || apb_fired) begin
            quiet_cycles = 0;
            apb_fired = 1'b0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles > 100000) begin
            $display("FAIL escape_time_fractal_pixel_core");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed table: pixel rows and register rows in one list
    // ------------------------------------------------------------------
    typedef enum logic { ROW_PIXEL, ROW_WRITE } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [2:0]  reg_idx;
        logic [31:0] value;     // pixel index or register value
        bit          typed;     // expected count read straight off the row
        logic [23:0] count;
    } stim_row_t;

    localparam int N_ROWS = 24;
    stim_row_t stim_rows[N_ROWS] = '{
        // reset registers: c = (-2,-2) escapes on the first step
        '{ROW_PIXEL, efp_pkg::REG_ITER_LIMIT, 32'd0, 1'b1, 24'd1},
        // pixel mapping to c = 0 never escapes
        '{ROW_PIXEL, efp_pkg::REG_ITER_LIMIT, 32'd524800, 1'b1, 24'd1024},
        '{ROW_PIXEL, efp_pkg::REG_ITER_LIMIT, 32'hFFFFFF, 1'b0, 24'd0},
        '{ROW_PIXEL, efp_pkg::REG_ITER_LIMIT, 32'd1023, 1'b0, 24'd0},
        // zero limit: no iteration at all
        '{ROW_WRITE, efp_pkg::REG_ITER_LIMIT, 32'd0, 1'b0, 24'd0},
        '{ROW_PIXEL, efp_pkg::REG_ITER_LIMIT, 32'd524800, 1'b1, 24'd0},
        '{ROW_PIXEL, efp_pkg::REG_ITER_LIMIT, 32'hFFFFFF, 1'b1, 24'd0},
        // largest limit, with a point that leaves at once
        '{ROW_WRITE, efp_pkg::REG_ITER_LIMIT, 32'hFFFFFF, 1'b0, 24'd0},
        '{ROW_PIXEL, efp_pkg::REG_ITER_LIMIT, 32'd0, 1'b1, 24'd1},
        '{ROW_WRITE, efp_pkg::REG_ITER_LIMIT, 32'd64, 1'b0, 24'd0},
        // zero width behaves as one column
        '{ROW_WRITE, efp_pkg::REG_IMAGE_WIDTH, 32'd0, 1'b0, 24'd0},
        '{ROW_PIXEL, efp_pkg::REG_ITER_LIMIT, 32'd5, 1'b0, 24'd0},
        // width above the maximum saturates
        '{ROW_WRITE, efp_pkg::REG_IMAGE_WIDTH, 32'd8191, 1'b0, 24'd0},
        '{ROW_PIXEL, efp_pkg::REG_ITER_LIMIT, 32'd4097, 1'b0, 24'd0},
        '{ROW_WRITE, efp_pkg::REG_IMAGE_WIDTH, 32'd4096, 1'b0, 24'd0},
        '{ROW_PIXEL, efp_pkg::REG_ITER_LIMIT, 32'hABCDEF, 1'b0, 24'd0},
        // coordinate extremes, sums wrap
        '{ROW_WRITE, efp_pkg::REG_X_LEFT, 32'h7FFF_FFFF, 1'b0, 24'd0},
        '{ROW_WRITE, efp_pkg::REG_X_STEP, 32'h8000_0000, 1'b0, 24'd0},
        '{ROW_WRITE, efp_pkg::REG_Y_BOTTOM, 32'h8000_0000, 1'b0, 24'd0},
        '{ROW_WRITE, efp_pkg::REG_Y_STEP, 32'h7FFF_FFFF, 1'b0, 24'd0},
        '{ROW_PIXEL, efp_pkg::REG_ITER_LIMIT, 32'd1, 1'b0, 24'd0},
        '{ROW_PIXEL, efp_pkg::REG_ITER_LIMIT, 32'hFFFFFF, 1'b0, 24'd0},
        '{ROW_WRITE, efp_pkg::REG_IMAGE_WIDTH, 32'd1, 1'b0, 24'd0},
        '{ROW_PIXEL, efp_pkg::REG_ITER_LIMIT, 32'h555555, 1'b0, 24'd0}
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned w, col, row;
        logic [23:0] pix;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 10;
        rx_idle_pct = 82;
        for (int r = 0; r < N_ROWS; r++) begin
            if (stim_rows[r].kind == ROW_WRITE) begin
                s_tvalid <= 1'b0;
                write_reg(stim_rows[r].reg_idx, stim_rows[r].value);
            end else begin
                send_pixel(stim_rows[r].value[23:0], stim_rows[r].typed,
                           stim_rows[r].count);
            end
        end
        s_tvalid <= 1'b0;

        // random phases: new registers each time, then ~56 pixels
        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 4) begin
                tx_idle_pct = 82;
                rx_idle_pct = 10;
            end else if (ph == 7) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            s_tvalid <= 1'b0;
            write_reg(efp_pkg::REG_ITER_LIMIT, (ph == 3) ? $urandom_range(200, 400)
                                                         : $urandom_range(0, 48));
            case ($urandom_range(0, 5))
                0:       write_reg(efp_pkg::REG_IMAGE_WIDTH, 0);
                1:       write_reg(efp_pkg::REG_IMAGE_WIDTH, $urandom_range(4097, 8191));
                default: write_reg(efp_pkg::REG_IMAGE_WIDTH, $urandom_range(1, 4096));
            endcase
            if (ph == 8) begin
                // noise: fully random plane
                write_reg(efp_pkg::REG_X_LEFT, $urandom());
                write_reg(efp_pkg::REG_X_STEP, $urandom());
                write_reg(efp_pkg::REG_Y_BOTTOM, $urandom());
                write_reg(efp_pkg::REG_Y_STEP, $urandom());
            end else begin
                // a window near the set, so iteration runs deep
                write_reg(efp_pkg::REG_X_LEFT, $urandom_range(0, 939524096) - 671088640);
                write_reg(efp_pkg::REG_X_STEP, $urandom_range(0, 1 << 23) - (1 << 22));
                write_reg(efp_pkg::REG_Y_BOTTOM, $urandom_range(0, 805306368) - 402653184);
                write_reg(efp_pkg::REG_Y_STEP, $urandom_range(0, 1 << 23) - (1 << 22));
            end
            if (ph == 7) backpressure_req = 1'b1;
            w = eff_width();
            for (int i = 0; i < 56; i++) begin
                if ($urandom_range(0, 3) == 0) begin
                    pix = 24'($urandom());
                end else begin
                    col = $urandom_range(0, w - 1);
                    row = $urandom_range(0, 255);
                    pix = 24'(row * w + col);
                end
                send_pixel(pix, 1'b0, 24'd0);
            end
        end
        s_tvalid <= 1'b0;

        while (expected_counts.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);

        $display("sent %0d pixels, checked %0d escape counts, %0d register writes",
                 pixels_sent, counts_checked, reg_writes);
        $display("covered limit/width extremes, wrapping coordinates, stalls, backpressure");
        if (mismatches == 0 && expected_counts.size() == 0)
            $display("PASS escape_time_fractal_pixel_core");
        else
            $display("FAIL escape_time_fractal_pixel_core");
        $finish;
    end

endmodule

/* sim.f */
design/efp_pkg.sv
design/efp_front.sv
design/efp_queue.sv
design/efp_back.sv
design/escape_time_fractal_pixel_core.sv
design/efp_checker.sv
tb/tb_top.sv
